/* hdl/itoa_pkg.sv */
// itoa_pkg: item types, kind codes and digit lookup for the integer to ascii formatter
// no dependencies; used by every module of the block
package itoa_pkg;

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_HEXL = 3'd2;
  localparam logic [2:0] KIND_HEXU = 3'd3;
  localparam logic [2:0] KIND_PTR  = 3'd4;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;

  localparam logic [4:0] DEC_DIGITS = 5'd10;
  localparam logic [4:0] HEX_DIGITS = 5'd8;
  localparam logic [4:0] PTR_DIGITS = 5'd16;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  kind;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic [4:0] total_chars;
  } out_item_t;

  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_MINUS = 2'd1,
    PFX_HEX   = 2'd2
  } prefix_e;

  // digits left-aligned: the most significant nibble sits in bits 63:60
  typedef struct packed {
    logic        load;
    logic [63:0] digits;
    logic [4:0]  ndig;
    prefix_e     prefix;
    logic        upper;
  } ser_load_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else if (upper) begin
      c = 8'h37 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

/* hdl/itoa_dabble.sv */
// itoa_dabble: bit-serial binary to bcd conversion of a 32-bit magnitude, one bit per cycle
// depends on itoa_pkg
module itoa_dabble (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] bin_i,
  output logic        done_o,
  output logic [39:0] bcd_o
);
  import itoa_pkg::*;

  logic [31:0] bin_q, bin_d;
  logic [39:0] bcd_q, bcd_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [39:0] adj;

  // add three to every bcd digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[38:0], bin_q[31]};
      bin_d = {bin_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

/* hdl/itoa_serializer.sv */
// itoa_serializer: strips leading zeros then sends prefix and digits, one a cycle if not stalled
// depends on itoa_pkg
module itoa_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itoa_pkg::ser_load_t  load_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output itoa_pkg::out_item_t  out_item_o
);
  import itoa_pkg::*;

  typedef enum logic [3:0] {
    SS_IDLE = 4'b0001,
    SS_NORM = 4'b0010,
    SS_PREF = 4'b0100,
    SS_DIGS = 4'b1000
  } ser_state_e;

  ser_state_e  state_q, state_d;
  logic [63:0] dig_q, dig_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  pref_q, pref_d;
  logic        minus_q, minus_d;
  logic        upper_q, upper_d;
  logic [4:0]  tot_q, tot_d;
  logic        ovld_q, ovld_d;
  out_item_t   oitem_q, oitem_d;
  logic        fire;

  // output register is free when empty or being taken this cycle
  assign fire = !ovld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    pref_d  = pref_q;
    minus_d = minus_q;
    upper_d = upper_q;
    tot_d   = tot_q;
    ovld_d  = ovld_q && out_stall_i;
    oitem_d = oitem_q;
    case (state_q)
      SS_IDLE: begin
        if (load_i.load) begin
          dig_d   = load_i.digits;
          cnt_d   = load_i.ndig;
          upper_d = load_i.upper;
          minus_d = (load_i.prefix == PFX_MINUS);
          case (load_i.prefix)
            PFX_MINUS: pref_d = 2'd1;
            PFX_HEX:   pref_d = 2'd2;
            default:   pref_d = 2'd0;
          endcase
          state_d = SS_NORM;
        end
      end
      SS_NORM: begin
        if (dig_q[63:60] == 4'd0 && cnt_q > 5'd1) begin
          dig_d = {dig_q[59:0], 4'd0};
          cnt_d = cnt_q - 5'd1;
        end else begin
          tot_d   = cnt_q + {3'd0, pref_q};
          state_d = (pref_q != 2'd0) ? SS_PREF : SS_DIGS;
        end
      end
      SS_PREF: begin
        if (fire) begin
          ovld_d = 1'b1;
          if (minus_q) begin
            oitem_d.char_code = CHAR_MINUS;
          end else if (pref_q == 2'd2) begin
            oitem_d.char_code = CHAR_ZERO;
          end else begin
            oitem_d.char_code = CHAR_X;
          end
          oitem_d.last        = 1'b0;
          oitem_d.total_chars = tot_q;
          pref_d = pref_q - 2'd1;
          if (pref_q == 2'd1) begin
            state_d = SS_DIGS;
          end
        end
      end
      SS_DIGS: begin
        if (fire) begin
          ovld_d              = 1'b1;
          oitem_d.char_code   = digit_char(dig_q[63:60], upper_q);
          oitem_d.last        = (cnt_q == 5'd1);
          oitem_d.total_chars = tot_q;
          dig_d = {dig_q[59:0], 4'd0};
          cnt_d = cnt_q - 5'd1;
          if (cnt_q == 5'd1) begin
            state_d = SS_IDLE;
          end
        end
      end
      default: state_d = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SS_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
    pref_q  <= pref_d;
    minus_q <= minus_d;
    upper_q <= upper_d;
    tot_q   <= tot_d;
    oitem_q <= oitem_d;
  end

  assign busy_o      = (state_q != SS_IDLE);
  assign out_valid_o = ovld_q;
  assign out_item_o  = oitem_q;

endmodule

/* hdl/integer_to_ascii_formatter.sv */
// integer_to_ascii_formatter: top level, takes a value and format kind and sends its text
// depends on itoa_pkg, itoa_dabble and itoa_serializer
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | in_item_i  (value, kind)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (char_code, last, total_chars)
//
// decimal kinds: the bit-serial bcd converter shifts in the accepted magnitude, then the
// serializer takes the bcd digits, drops leading zeros and sizes the text, and sends a
// minus sign if negative and then the digits. hex kinds and pointers load the serializer
// at once. no new item is taken until the serializer is back to idle.
// reset clears the control state only; an unused kind is taken and dropped.
// a stalled output holds its character and stops the character sequence.
module integer_to_ascii_formatter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itoa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itoa_pkg::out_item_t out_item_o
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_WAIT = 3'b100
  } top_state_e;

  top_state_e  state_q, state_d;
  logic        neg_q, neg_d;
  logic        accept;
  logic        is_dec;
  logic        neg;
  logic [31:0] low;
  logic [31:0] mag;
  logic        conv_done;
  logic [39:0] bcd;
  logic        ser_busy;
  ser_load_t   sload;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign low        = in_item_i.value[31:0];
  assign is_dec     = (in_item_i.kind == KIND_SDEC) || (in_item_i.kind == KIND_UDEC);
  assign neg        = (in_item_i.kind == KIND_SDEC) && low[31];
  assign mag        = neg ? (~low + 32'd1) : low;

  itoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && is_dec),
    .bin_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  always_comb begin
    sload.load   = 1'b0;
    sload.digits = {bcd, 24'd0};
    sload.ndig   = DEC_DIGITS;
    sload.prefix = neg_q ? PFX_MINUS : PFX_NONE;
    sload.upper  = 1'b0;
    if (state_q == ST_CONV) begin
      sload.load = conv_done;
    end else if (accept) begin
      case (in_item_i.kind)
        KIND_HEXL, KIND_HEXU: begin
          sload.load   = 1'b1;
          sload.digits = {low, 32'd0};
          sload.ndig   = HEX_DIGITS;
          sload.prefix = PFX_NONE;
          sload.upper  = (in_item_i.kind == KIND_HEXU);
        end
        KIND_PTR: begin
          sload.load   = 1'b1;
          sload.digits = in_item_i.value;
          sload.ndig   = PTR_DIGITS;
          sload.prefix = PFX_HEX;
        end
        default: sload.load = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d = neg;
          if (is_dec) begin
            state_d = ST_CONV;
          end else if (sload.load) begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!ser_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
  end

  itoa_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (sload),
    .busy_o      (ser_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for integer_to_ascii_formatter, predicts every character
// from the number and kind, then compares each character sent with the oldest expected one
// depends on itoa_pkg and integer_to_ascii_formatter
`timescale 1ns / 1ps

module testbench;
  import itoa_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;
  localparam int MAX_REPORTED = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;

  typedef enum logic [2:0] {
    PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH, PH_HOLD
  } phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  in_item_t pending_numbers[$];
  out_item_t expected_chars[$];
  int char_errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  phase_e phase = PH_STEADY;
  int hold_left;
  logic hold_armed;

  integer_to_ascii_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // text of one number, most significant digit first, sign or prefix ahead
  function automatic void queue_expected_text(input in_item_t item);
    logic [7:0] text[$];
    logic [63:0] mag;
    logic [31:0] low;
    logic [31:0] neg;
    logic [63:0] radix;
    logic [3:0] d;
    logic upper;
    logic minus;
    logic ptr;
    out_item_t c;
    low = item.value[31:0];
    mag = {32'd0, low};
    radix = 64'd16;
    upper = 1'b0;
    minus = 1'b0;
    ptr = 1'b0;
    case (item.kind)
      KIND_SDEC: begin
        radix = 64'd10;
        if (low[31]) begin
          minus = 1'b1;
          neg = -low;
          mag = {32'd0, neg};
        end
      end
      KIND_UDEC: radix = 64'd10;
      KIND_HEXL: ;
      KIND_HEXU: upper = 1'b1;
      KIND_PTR: begin
        mag = item.value;
        ptr = 1'b1;
      end
      default: return;  // spare kinds are dropped by the block
    endcase
    do begin
      d = 4'(mag % radix);
      if (d < 4'd10) text.push_front(8'h30 + {4'd0, d});
      else if (upper) text.push_front(8'h41 + {4'd0, d} - 8'd10);
      else text.push_front(8'h61 + {4'd0, d} - 8'd10);
      mag = mag / radix;
    end while (mag != 0);
    if (minus) text.push_front(8'h2d);
    if (ptr) begin
      text.push_front(8'h78);
      text.push_front(8'h30);
    end
    foreach (text[k]) begin
      c.char_code = text[k];
      c.last = (k == text.size() - 1);
      c.total_chars = 5'(text.size());
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = 64'($urandom_range(0, 20));
      3: v = -64'($urandom_range(1, 20));
      4: begin
        // around a power of ten, where the digit count changes
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = {$urandom, 32'h8000_0000};
          1: v = '1;
          2: v = {$urandom, 32'h7fff_ffff};
          default: v = {$urandom, 32'h0};
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t random_number();
    in_item_t item;
    item.value = random_value();
    if ($urandom_range(0, 99) < 5) item.kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
    else item.kind = 3'($urandom_range(KIND_SDEC, KIND_PTR));
    return item;
  endfunction

  function automatic in_item_t make_number(input logic [63:0] v, input logic [2:0] k);
    in_item_t item;
    item.value = v;
    item.kind = k;
    return item;
  endfunction

  // driver: offers queued numbers, holds a stalled item unchanged
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) queue_expected_text(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_numbers.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started once when the hold phase begins
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (phase == PH_HOLD && hold_armed) begin
      hold_left <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each character taken against the oldest expected one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          char_errors++;
          if (char_errors <= MAX_REPORTED)
            $display("unexpected char %h last %b total %0d with nothing pending",
                     out_item.char_code, out_item.last, out_item.total_chars);
        end else if (out_item !== expected_chars[0]) begin
          char_errors++;
          if (char_errors <= MAX_REPORTED)
            $display("mismatch: expected char %h last %b total %0d, got char %h last %b total %0d",
                     expected_chars[0].char_code, expected_chars[0].last,
                     expected_chars[0].total_chars, out_item.char_code, out_item.last,
                     out_item.total_chars);
          void'(expected_chars.pop_front());
        end else begin
          void'(expected_chars.pop_front());
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic run_phase(input phase_e p, input int sidle, input int rstall, input int count);
    @(negedge clk_i);
    phase = p;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (count) pending_numbers.push_back(random_number());
    // sender pauses here until every character of the phase has come back
    while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed numbers: extremes, every kind, sign and prefix cases, spare kinds
    pending_numbers.push_back(make_number(64'd0, KIND_SDEC));
    pending_numbers.push_back(make_number(64'd1, KIND_SDEC));
    pending_numbers.push_back(make_number(64'hffff_ffff_ffff_ffff, KIND_SDEC));
    pending_numbers.push_back(make_number(64'h0000_0000_7fff_ffff, KIND_SDEC));
    pending_numbers.push_back(make_number(64'h0000_0000_8000_0000, KIND_SDEC));
    pending_numbers.push_back(make_number(64'h1234_5678_8000_0001, KIND_SDEC));
    pending_numbers.push_back(make_number(64'h0000_0000_ffff_fff6, KIND_SDEC));
    pending_numbers.push_back(make_number(64'd0, KIND_UDEC));
    pending_numbers.push_back(make_number(64'hffff_ffff_ffff_ffff, KIND_UDEC));
    pending_numbers.push_back(make_number(64'd9, KIND_UDEC));
    pending_numbers.push_back(make_number(64'hffff_0000_0000_000a, KIND_UDEC));
    pending_numbers.push_back(make_number(64'd1_000_000_000, KIND_UDEC));
    pending_numbers.push_back(make_number(64'd0, KIND_HEXL));
    pending_numbers.push_back(make_number(64'h5555_aaaa_dead_beef, KIND_HEXL));
    pending_numbers.push_back(make_number(64'h0000_0000_abcd_ef01, KIND_HEXL));
    pending_numbers.push_back(make_number(64'hffff_ffff_ffff_ffff, KIND_HEXU));
    pending_numbers.push_back(make_number(64'h0000_0000_0000_000a, KIND_HEXU));
    pending_numbers.push_back(make_number(64'd0, KIND_PTR));
    pending_numbers.push_back(make_number(64'hffff_ffff_ffff_ffff, KIND_PTR));
    pending_numbers.push_back(make_number(64'd1, KIND_PTR));
    pending_numbers.push_back(make_number(64'h1234_5678_9abc_def0, KIND_PTR));
    pending_numbers.push_back(make_number(64'hffff_ffff_ffff_ffff, KIND_SPARE_A));
    pending_numbers.push_back(make_number(64'd7, KIND_SPARE_C));
    pending_numbers.push_back(make_number(64'd42, KIND_UDEC));

    run_phase(PH_STEADY, 0, 0, 50);
    run_phase(PH_SEND_GAPS, 49, 0, 50);
    run_phase(PH_RECV_STALLS, 0, 49, 50);
    run_phase(PH_BOTH, 23, 23, 60);
    run_phase(PH_HOLD, 0, 0, 50);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (char_errors == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (expected_chars.size() != 0)
        $display("%0d expected chars never arrived", expected_chars.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d chars still expected", expected_chars.size());
    $display("FAILURE");
    $finish;
  end

endmodule
